[rtl/bbd_pkg.sv]
package bbd_pkg;

  localparam int MaxWidthDefault = 4096;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WIDTH   = 2'd0,
    CFG_HEIGHT  = 2'd1,
    CFG_PATTERN = 2'd2
  } cfg_idx_e;

  localparam logic [12:0] WidthReset   = 13'd640;
  localparam logic [15:0] HeightReset  = 16'd480;
  localparam logic [1:0]  PatternReset = 2'd0;

  // column of three samples, index 0 is the upper row
  typedef logic [2:0][7:0] col_t;
  // grid[row][col], rows up/centre/down, cols left/centre/right
  typedef logic [2:0][2:0][7:0] grid_t;

  typedef struct packed {
    logic up;
    logic dn;
    logic lf;
    logic rt;
    logic er_odd;
    logic ec_odd;
  } pix_ctl_t;

  // rounded mean of n samples, divide by three through a reciprocal
  function automatic logic [7:0] mean_of(input logic [9:0] sum, input logic [2:0] n);
    logic [10:0] s1;
    logic [21:0] prod;
    logic [10:0] s2;
    logic [7:0]  res;
    s1   = {1'b0, sum} + 11'd1;
    s2   = {1'b0, sum} + 11'd2;
    prod = {11'd0, s1} * 22'd683;
    res  = '0;
    unique case (n)
      3'd1: res = sum[7:0];
      3'd2: res = s1[8:1];
      3'd3: res = prod[18:11];
      3'd4: res = s2[9:2];
      default: res = '0;
    endcase
    return res;
  endfunction

endpackage

[rtl/bbd_ram.sv]
module bbd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/bbd_pixel.sv]
module bbd_pixel (
  input  bbd_pkg::grid_t    grid_i,
  input  bbd_pkg::pix_ctl_t ctl_i,
  input  logic [1:0]        pattern_i,
  output logic [7:0]        blue_o,
  output logic [7:0]        green_o,
  output logic [7:0]        red_o
);

  logic [9:0] vs, hs, ds, xs;
  logic [2:0] vn, hn, dnum, xn;
  logic [7:0] v, h, d, x, ctr;
  logic       sg, bl, is_green;

  always_comb begin
    vs   = '0;
    hs   = '0;
    ds   = '0;
    vn   = '0;
    hn   = '0;
    dnum = '0;
    if (ctl_i.up) begin
      vs = vs + {2'd0, grid_i[0][1]};
      vn = vn + 3'd1;
    end
    if (ctl_i.dn) begin
      vs = vs + {2'd0, grid_i[2][1]};
      vn = vn + 3'd1;
    end
    if (ctl_i.lf) begin
      hs = hs + {2'd0, grid_i[1][0]};
      hn = hn + 3'd1;
    end
    if (ctl_i.rt) begin
      hs = hs + {2'd0, grid_i[1][2]};
      hn = hn + 3'd1;
    end
    if (ctl_i.up && ctl_i.lf) begin
      ds   = ds + {2'd0, grid_i[0][0]};
      dnum = dnum + 3'd1;
    end
    if (ctl_i.up && ctl_i.rt) begin
      ds   = ds + {2'd0, grid_i[0][2]};
      dnum = dnum + 3'd1;
    end
    if (ctl_i.dn && ctl_i.lf) begin
      ds   = ds + {2'd0, grid_i[2][0]};
      dnum = dnum + 3'd1;
    end
    if (ctl_i.dn && ctl_i.rt) begin
      ds   = ds + {2'd0, grid_i[2][2]};
      dnum = dnum + 3'd1;
    end
    xs = vs + hs;
    xn = vn + hn;
  end

  assign v   = bbd_pkg::mean_of(vs, vn);
  assign h   = bbd_pkg::mean_of(hs, hn);
  assign d   = bbd_pkg::mean_of(ds, dnum);
  assign x   = bbd_pkg::mean_of(xs, xn);
  assign ctr = grid_i[1][1];

  // phase of the site from pattern and position parity
  assign sg       = pattern_i[1] ^ ctl_i.er_odd;
  assign bl       = ~pattern_i[0] ^ ctl_i.er_odd;
  assign is_green = ctl_i.ec_odd ^ sg;

  always_comb begin
    if (is_green) begin
      green_o = ctr;
      blue_o  = bl ? h : v;
      red_o   = bl ? v : h;
    end else begin
      green_o = x;
      blue_o  = bl ? ctr : d;
      red_o   = bl ? d : ctr;
    end
  end

endmodule

[rtl/bayer_bilinear_demosaic.sv]
// channel | direction | handshake              | payload
// raw     | in        | raw_valid_i/raw_ready_o | raw_pixel_i
// out     | out       | out_valid_o/out_ready_i | blue, green, red, out_row, out_col,
//         |           |                        | run_last, frame_done
// cfg     | in        | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// one raw sample per cycle while each sample causes at most one result and the
// output is not stalled; a sample that causes n results (up to 4 at the last
// sample) holds the input until the single output register, which takes one
// transaction per cycle, has loaded them all; the line memory is read once per
// sample as it is accepted and written once as it leaves the holding stage; reset
// clears counters and window and loads config reset values; line memory contents
// stay undefined; output stalls back up through the holding stage into raw_ready_o
module bayer_bilinear_demosaic #(
  parameter int MAX_WIDTH = bbd_pkg::MaxWidthDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         raw_valid_i,
  output logic                         raw_ready_o,
  input  logic [7:0]                   raw_pixel_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [7:0]                   blue_o,
  output logic [7:0]                   green_o,
  output logic [7:0]                   red_o,
  output logic [15:0]                  out_row_o,
  output logic [11:0]                  out_col_o,
  output logic                         run_last_o,
  output logic                         frame_done_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [bbd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [bbd_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = CW + 1;

  // configuration
  logic [12:0] cfg_width_q;
  logic [15:0] cfg_height_q;
  logic [1:0]  cfg_pattern_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q   <= bbd_pkg::WidthReset;
      cfg_height_q  <= bbd_pkg::HeightReset;
      cfg_pattern_q <= bbd_pkg::PatternReset;
    end else if (cfg_valid_i) begin
      unique case (bbd_pkg::cfg_idx_e'(cfg_index_i))
        bbd_pkg::CFG_WIDTH:   cfg_width_q   <= cfg_data_i[12:0];
        bbd_pkg::CFG_HEIGHT:  cfg_height_q  <= cfg_data_i;
        bbd_pkg::CFG_PATTERN: cfg_pattern_q <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  logic [WW-1:0] width_cl;
  logic [15:0]   height_cl;

  always_comb begin
    if ({19'd0, cfg_width_q} < 32'd4) begin
      width_cl = WW'(4);
    end else if ({19'd0, cfg_width_q} > 32'(MAX_WIDTH)) begin
      width_cl = WW'(MAX_WIDTH);
    end else begin
      width_cl = WW'(cfg_width_q);
    end
    height_cl = (cfg_height_q < 16'd2) ? 16'd2 : cfg_height_q;
  end

  // position counters
  logic [CW-1:0] col_q, col_d;
  logic [15:0]   row_q, row_d;
  logic          end_row, last_row, in_acc;

  assign end_row  = ({1'b0, col_q} + WW'(1)) >= width_cl;
  assign last_row = ({1'b0, row_q} + 17'd1) >= {1'b0, height_cl};
  assign in_acc   = raw_valid_i & raw_ready_o;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_acc) begin
      if (end_row) begin
        col_d = '0;
        row_d = last_row ? 16'd0 : row_q + 16'd1;
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // holding stage: one sample whose results are being produced
  logic          p_valid_q, p_valid_d;
  logic [3:0]    p_mask_q, p_mask_d;
  logic [7:0]    p_x_q;
  logic [CW-1:0] p_col_q;
  logic [15:0]   p_row_q;
  logic [3:0]    new_mask, sel, rest;
  logic          emit, p_finish, out_load;

  assign new_mask = {last_row & end_row,
                     last_row & (col_q != '0),
                     (row_q != 16'd0) & end_row,
                     (row_q != 16'd0) & (col_q != '0)};

  assign sel      = p_mask_q & (~p_mask_q + 4'd1);
  assign rest     = p_mask_q & ~sel;
  assign out_load = ~out_valid_o | out_ready_i;
  assign emit     = p_valid_q & (p_mask_q != 4'd0) & out_load;
  assign p_finish = p_valid_q & ((p_mask_q == 4'd0) | (emit & (rest == 4'd0)));
  assign raw_ready_o = ~p_valid_q | p_finish;

  always_comb begin
    p_valid_d = p_valid_q;
    p_mask_d  = p_mask_q;
    if (emit) begin
      p_mask_d = rest;
    end
    if (p_finish) begin
      p_valid_d = 1'b0;
    end
    if (in_acc) begin
      p_valid_d = 1'b1;
      p_mask_d  = new_mask;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      p_mask_q  <= '0;
    end else begin
      p_valid_q <= p_valid_d;
      p_mask_q  <= p_mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      p_x_q   <= raw_pixel_i;
      p_col_q <= col_q;
      p_row_q <= row_q;
    end
  end

  // line memory: upper row in the high byte, middle row in the low byte
  logic [15:0] line_rd;

  bbd_ram #(
    .WIDTH(16),
    .DEPTH(MAX_WIDTH)
  ) u_line (
    .clk_i  (clk_i),
    .we_i   (p_finish),
    .waddr_i(p_col_q),
    .wdata_i({line_rd[7:0], p_x_q}),
    .re_i   (in_acc),
    .raddr_i(col_q),
    .rdata_o(line_rd)
  );

  // window of the two previous columns
  bbd_pkg::col_t win_a_q, win_b_q, col_c;

  assign col_c = {p_x_q, line_rd[7:0], line_rd[15:8]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_a_q <= '0;
      win_b_q <= '0;
    end else if (p_finish) begin
      win_a_q <= win_b_q;
      win_b_q <= col_c;
    end
  end

  // pick the grid and borders of the result being emitted
  bbd_pkg::col_t     cl, cm, cr;
  bbd_pkg::grid_t    grid;
  bbd_pkg::pix_ctl_t ctl;
  logic              ro, done;
  logic [15:0]       er;
  logic [CW-1:0]     ec;
  logic              c_ge1, c_ge2, r_ge2;

  assign c_ge1 = p_col_q != '0;
  assign c_ge2 = p_col_q >= CW'(2);
  assign r_ge2 = p_row_q >= 16'd2;

  always_comb begin
    cl   = win_a_q;
    cm   = win_b_q;
    cr   = col_c;
    ro   = 1'b0;
    done = 1'b0;
    er   = p_row_q - 16'd1;
    ec   = p_col_q - CW'(1);
    ctl  = '0;
    priority if (sel[0]) begin
      ctl.up = r_ge2;
      ctl.dn = 1'b1;
      ctl.lf = c_ge2;
      ctl.rt = 1'b1;
    end else if (sel[1]) begin
      cl     = win_b_q;
      cm     = col_c;
      cr     = '0;
      ec     = p_col_q;
      ctl.up = r_ge2;
      ctl.dn = 1'b1;
      ctl.lf = c_ge1;
    end else if (sel[2]) begin
      ro     = 1'b1;
      er     = p_row_q;
      ctl.up = 1'b1;
      ctl.lf = c_ge2;
      ctl.rt = 1'b1;
    end else begin
      cl     = win_b_q;
      cm     = col_c;
      cr     = '0;
      ro     = 1'b1;
      er     = p_row_q;
      ec     = p_col_q;
      done   = 1'b1;
      ctl.up = 1'b1;
      ctl.lf = c_ge1;
    end
    ctl.er_odd = er[0];
    ctl.ec_odd = ec[0];
    // last-row results drop the top row of the window and shift the others up
    if (ro) begin
      grid[0] = {cr[1], cm[1], cl[1]};
      grid[1] = {cr[2], cm[2], cl[2]};
      grid[2] = '0;
    end else begin
      grid[0] = {cr[0], cm[0], cl[0]};
      grid[1] = {cr[1], cm[1], cl[1]};
      grid[2] = {cr[2], cm[2], cl[2]};
    end
  end

  logic [7:0] pix_b, pix_g, pix_r;

  bbd_pixel u_pixel (
    .grid_i   (grid),
    .ctl_i    (ctl),
    .pattern_i(cfg_pattern_q),
    .blue_o   (pix_b),
    .green_o  (pix_g),
    .red_o    (pix_r)
  );

  // output register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      blue_o       <= pix_b;
      green_o      <= pix_g;
      red_o        <= pix_r;
      out_row_o    <= er;
      out_col_o    <= 12'(ec);
      run_last_o   <= rest == 4'd0;
      frame_done_o <= done;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[bench/bayer_bilinear_demosaic_tb.sv]
`timescale 1ns / 100ps

module bayer_bilinear_demosaic_tb;

  localparam int LineDepth = bbd_pkg::MaxWidthDefault;
  localparam int IdxW = $clog2(LineDepth);
  localparam int StallLimit = 5000;

  typedef struct {
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [15:0] row;
    logic [11:0] col;
    logic        run_last;
    logic        frame_done;
  } bgr_pixel_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic raw_valid_i = 1'b0;
  logic raw_ready_o;
  logic [7:0] raw_pixel_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [7:0] blue_o, green_o, red_o;
  logic [15:0] out_row_o;
  logic [11:0] out_col_o;
  logic run_last_o, frame_done_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [bbd_pkg::CfgIdxW-1:0] cfg_index_i = bbd_pkg::CFG_WIDTH;
  logic [bbd_pkg::CfgDataW-1:0] cfg_data_i = '0;

  bayer_bilinear_demosaic DUT (.*);

  always #10 clk_i = ~clk_i;

  // shadow of the block state
  logic [7:0]    upper_mem [LineDepth];
  logic [7:0]    middle_mem [LineDepth];
  bbd_pkg::col_t win_left, win_mid;
  int unsigned   col_cnt, row_cnt;
  logic [12:0]   cfg_width;
  logic [15:0]   cfg_height;
  logic [1:0]    cfg_pattern;

  bgr_pixel_t  pending_pixels[$];
  int          errors;
  int          pixels_sent, pixels_checked, frames_seen, cfg_writes;
  int          send_idle_pct, recv_stall_pct;
  int          quiet_cycles;

  function automatic int round_mean(int sum, int n);
    case (n)
      1: return sum;
      2: return (sum + 1) >> 1;
      3: return (sum + 1) / 3;
      4: return (sum + 2) >> 2;
      default: return 0;
    endcase
  endfunction

  function automatic void push_pixel(bbd_pkg::col_t lc, bbd_pkg::col_t cc, bbd_pkg::col_t rc,
                                     int ro, bit up, bit dn, bit lf, bit rt, int er, int ec,
                                     bit done);
    int g[3][3];
    int vs, vn, hs, hn, ds, dcount;
    int v, hm, dm, xm;
    bit sg, bl, grn;
    bgr_pixel_t e;
    for (int i = 0; i < 3; i++) begin
      g[i][0] = (i + ro < 3) ? lc[i+ro] : 0;
      g[i][1] = (i + ro < 3) ? cc[i+ro] : 0;
      g[i][2] = (i + ro < 3) ? rc[i+ro] : 0;
    end
    vs = 0; vn = 0; hs = 0; hn = 0; ds = 0; dcount = 0;
    if (up) begin vs += g[0][1]; vn++; end
    if (dn) begin vs += g[2][1]; vn++; end
    if (lf) begin hs += g[1][0]; hn++; end
    if (rt) begin hs += g[1][2]; hn++; end
    if (up && lf) begin ds += g[0][0]; dcount++; end
    if (up && rt) begin ds += g[0][2]; dcount++; end
    if (dn && lf) begin ds += g[2][0]; dcount++; end
    if (dn && rt) begin ds += g[2][2]; dcount++; end
    v = round_mean(vs, vn);
    hm = round_mean(hs, hn);
    dm = round_mean(ds, dcount);
    xm = round_mean(vs + hs, vn + hn);
    sg = (cfg_pattern >= 2) ^ er[0];
    bl = (cfg_pattern == 0 || cfg_pattern == 2) ^ er[0];
    grn = ec[0] ^ sg;
    if (grn) begin
      e.green = 8'(g[1][1]);
      e.blue = 8'(bl ? hm : v);
      e.red = 8'(bl ? v : hm);
    end else begin
      e.green = 8'(xm);
      e.blue = 8'(bl ? g[1][1] : dm);
      e.red = 8'(bl ? dm : g[1][1]);
    end
    e.row = er[15:0];
    e.col = ec[11:0];
    e.run_last = 1'b0;
    e.frame_done = done;
    pending_pixels.push_back(e);
  endfunction

  function automatic void predict_demosaic(logic [7:0] px);
    int unsigned w, hgt, c, r, n_prior;
    logic [IdxW-1:0] idx;
    bit end_row, last_row;
    bbd_pkg::col_t col_new;
    w = 32'(cfg_width);
    hgt = 32'(cfg_height);
    c = col_cnt;
    r = row_cnt;
    idx = IdxW'((c < LineDepth) ? c : LineDepth - 1);
    n_prior = pending_pixels.size();
    if (w < 4) w = 4;
    if (w > LineDepth) w = LineDepth;
    if (hgt < 2) hgt = 2;
    end_row = (c + 1 >= w);
    last_row = (r + 1 >= hgt);
    col_new[0] = upper_mem[idx];
    col_new[1] = middle_mem[idx];
    col_new[2] = px;
    upper_mem[idx] = col_new[1];
    middle_mem[idx] = px;
    if (r >= 1 && c >= 1)
      push_pixel(win_left, win_mid, col_new, 0, r >= 2, 1, c >= 2, 1, r - 1, c - 1, 0);
    if (r >= 1 && end_row)
      push_pixel(win_mid, col_new, '0, 0, r >= 2, 1, c >= 1, 0, r - 1, c, 0);
    if (last_row && c >= 1)
      push_pixel(win_left, win_mid, col_new, 1, 1, 0, c >= 2, 1, r, c - 1, 0);
    if (last_row && end_row)
      push_pixel(win_mid, col_new, '0, 1, 1, 0, c >= 1, 0, r, c, 1);
    if (pending_pixels.size() > n_prior) pending_pixels[$].run_last = 1'b1;
    win_left = win_mid;
    win_mid = col_new;
    if (end_row) begin
      col_cnt = 0;
      row_cnt = last_row ? 0 : ((r + 1) & 16'hFFFF);
    end else begin
      col_cnt = c + 1;
    end
  endfunction

  task automatic send_pixel(input logic [7:0] px);
    @(negedge clk_i);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      raw_valid_i = 1'b0;
      do @(negedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    raw_valid_i = 1'b1;
    raw_pixel_i = px;
    do @(posedge clk_i); while (!raw_ready_o);
    predict_demosaic(px);
    pixels_sent++;
  endtask

  // let the pipeline empty before touching the registers
  task automatic wait_idle();
    @(negedge clk_i);
    raw_valid_i = 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input bbd_pkg::cfg_idx_e idx,
                           input logic [bbd_pkg::CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      bbd_pkg::CFG_WIDTH:   cfg_width = data[12:0];
      bbd_pkg::CFG_HEIGHT:  cfg_height = data;
      bbd_pkg::CFG_PATTERN: cfg_pattern = data[1:0];
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic logic [7:0] rand_pixel();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // row 0 starts at the reset width, then the frame is cut short
  task automatic test_reset_width_cut();
    send_pixel(8'h00);
    send_pixel(8'hFF);
    send_pixel(8'h00);
    wait_idle();
    write_reg(bbd_pkg::CFG_WIDTH, 16'd4);
    write_reg(bbd_pkg::CFG_HEIGHT, 16'd2);
    send_pixel(8'hFF);
    send_pixel(8'hFF);
    send_pixel(8'h00);
    send_pixel(8'hFF);
    send_pixel(8'h00);
    wait_idle();
  endtask

  // out of range sizes saturate to the legal limits; the samples run at the lower ones
  task automatic test_size_saturation();
    write_reg(bbd_pkg::CFG_WIDTH, 16'h1FFF);
    write_reg(bbd_pkg::CFG_WIDTH, 16'd0);
    write_reg(bbd_pkg::CFG_HEIGHT, 16'd0);
    write_reg(bbd_pkg::CFG_PATTERN, 16'd3);
    for (int i = 0; i < 8; i++) send_pixel((i % 3 == 0) ? 8'hFF : 8'h01);
    wait_idle();
  endtask

  // tallest frame, height lowered while mid-frame and idle
  task automatic test_tall_frame_cut();
    write_reg(bbd_pkg::CFG_PATTERN, 16'd1);
    write_reg(bbd_pkg::CFG_HEIGHT, 16'hFFFF);
    for (int i = 0; i < 12; i++) send_pixel(rand_pixel());
    wait_idle();
    write_reg(bbd_pkg::CFG_HEIGHT, 16'd1);
    for (int i = 0; i < 4; i++) send_pixel(rand_pixel());
    wait_idle();
  endtask

  task automatic test_random_frames(input int idle_pct, input int stall_pct, input int items);
    int target, w, hgt;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    target = pixels_sent + items;
    while (pixels_sent < target) begin
      w = $urandom_range(4, 12);
      hgt = $urandom_range(2, 6);
      write_reg(bbd_pkg::CFG_WIDTH, 16'(w));
      write_reg(bbd_pkg::CFG_HEIGHT, 16'(hgt));
      write_reg(bbd_pkg::CFG_PATTERN, 16'($urandom_range(0, 3)));
      for (int i = 0; i < w * hgt; i++) send_pixel(rand_pixel());
      wait_idle();
    end
  endtask

  always @(negedge clk_i)
    out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);

  always @(posedge clk_i) begin
    bgr_pixel_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected output transaction row %0d col %0d", out_row_o, out_col_o);
        errors++;
      end else begin
        e = pending_pixels.pop_front();
        pixels_checked++;
        if (frame_done_o) frames_seen++;
        if (blue_o !== e.blue) begin
          $error("blue: expected %0d, got %0d", e.blue, blue_o); errors++;
        end
        if (green_o !== e.green) begin
          $error("green: expected %0d, got %0d", e.green, green_o); errors++;
        end
        if (red_o !== e.red) begin
          $error("red: expected %0d, got %0d", e.red, red_o); errors++;
        end
        if (out_row_o !== e.row) begin
          $error("out_row: expected %0d, got %0d", e.row, out_row_o); errors++;
        end
        if (out_col_o !== e.col) begin
          $error("out_col: expected %0d, got %0d", e.col, out_col_o); errors++;
        end
        if (run_last_o !== e.run_last) begin
          $error("run_last: expected %0d, got %0d", e.run_last, run_last_o); errors++;
        end
        if (frame_done_o !== e.frame_done) begin
          $error("frame_done: expected %0d, got %0d", e.frame_done, frame_done_o); errors++;
        end
      end
    end
  end

  // no transaction on any channel for too long means a hang
  always @(posedge clk_i) begin
    if (!rst_ni || (raw_valid_i && raw_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("timeout with %0d results outstanding", pending_pixels.size());
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    errors = 0;
    pixels_sent = 0;
    pixels_checked = 0;
    frames_seen = 0;
    cfg_writes = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    col_cnt = 0;
    row_cnt = 0;
    win_left = '0;
    win_mid = '0;
    cfg_width = bbd_pkg::WidthReset;
    cfg_height = bbd_pkg::HeightReset;
    cfg_pattern = bbd_pkg::PatternReset;
    foreach (upper_mem[i]) begin
      upper_mem[i] = '0;
      middle_mem[i] = '0;
    end
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_width_cut();
    test_size_saturation();
    test_tall_frame_cut();
    test_random_frames(17, 57, 90);
    test_random_frames(57, 17, 90);
    test_random_frames(0, 0, 90);

    $display("sent %0d raw samples, checked %0d pixels over %0d completed frames",
             pixels_sent, pixels_checked, frames_seen);
    $display("%0d register writes across all four patterns and size extremes", cfg_writes);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
